// ===== design/bfr_pkg.sv =====
// ----------------------------------------------------------------------------
// bfr_pkg
// Shared items for the reflect-border filter: states, regs, codes, widths.
// ----------------------------------------------------------------------------
package bfr_pkg;

    // Front end: wait for a word, then decide whether an output is due
    typedef enum logic {
        FE_IDLE,
        FE_CHECK
    } fe_state_t;

    // Back end: window sum, division, hand-off to the result queue
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SUM,
        BK_DIV,
        BK_PUT
    } bk_state_t;

    // Configuration register indexes
    localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_KERNEL_WIDTH  = 2'd2;
    localparam logic [1:0] REG_KERNEL_HEIGHT = 2'd3;

    // Request codes
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    // Row and divider widths fixed by the field sizes
    localparam int ROW_W = 16;
    localparam int SUM_W = 16;
    localparam int AREA_W = 8;

endpackage

// ===== design/box_filter_reflect_border_core.sv =====
// ----------------------------------------------------------------------------
// box_filter_reflect_border_core
// Streaming box (mean) filter over 8-bit frames with reflect-101 borders.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order; each output is the rounded mean of an odd
// window of 2*(kernel_width/2)+1 by 2*(kernel_height/2)+1 pixels, each half
// clamped to a limit set by the parameters, given once every pixel it needs
// has arrived, so results lag by about half the kernel in rows and columns.
// Drain words flush the outputs still pending at the end of a frame; a drain
// with nothing pending gives no result. The block takes one word at a time:
// a word that produces an output occupies it while the window is summed one
// pixel a cycle through the single read port of the line store and divided;
// a word that produces nothing frees it once the front end has checked it. A
// two-deep result queue lets the block finish the next word while a result
// waits to be popped. Configuration writes restart the frame.
// ----------------------------------------------------------------------------
module box_filter_reflect_border_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_KERNEL = 15,
    parameter int STORE_ROWS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        req_type,
    input  logic [7:0]  pixel_in,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  mean_out,
    output logic        row_end,
    output logic        frame_end,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int SW = (STORE_ROWS > 1) ? $clog2(STORE_ROWS) : 1;
    localparam int AW = SW + CW;
    localparam int JW = 16 + CW + 2;
    localparam int HX_LIM0 = MAX_KERNEL / 2;
    localparam int HX_LIM  = (HX_LIM0 < 7) ? HX_LIM0 : 7;
    localparam int HY_LIM1 = (STORE_ROWS - 2) / 2;
    localparam int HY_LIM  = (HY_LIM1 < HX_LIM) ? HY_LIM1 : HX_LIM;

    logic [10:0] image_width_reg;
    logic [15:0] image_height_reg;
    logic [3:0]  kernel_width_reg;
    logic [3:0]  kernel_height_reg;

    logic [WW-1:0] eff_width;
    logic [15:0]   eff_height;
    logic [2:0]    half_x;
    logic [2:0]    half_y;

    logic          accept;
    logic          front_busy;
    logic          back_busy;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic          job_push;
    logic [JW-1:0] job_in;
    logic [JW-1:0] job_out;
    logic          job_empty;
    logic          job_full;
    logic          job_pop;
    logic          res_push;
    logic [9:0]    res_in;
    logic [9:0]    res_out;
    logic          res_full;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg   <= 11'd640;
            image_height_reg  <= 16'd480;
            kernel_width_reg  <= 4'd3;
            kernel_height_reg <= 4'd3;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bfr_pkg::REG_IMAGE_WIDTH:   image_width_reg   <= cfg_data[10:0];
                bfr_pkg::REG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data;
                bfr_pkg::REG_KERNEL_WIDTH:  kernel_width_reg  <= cfg_data[3:0];
                bfr_pkg::REG_KERNEL_HEIGHT: kernel_height_reg <= cfg_data[3:0];
                default:                    image_width_reg   <= image_width_reg;
            endcase
        end
    end

    // Effective frame and window sizes
    always_comb
    begin
        if (image_width_reg == '0)
        begin
            eff_width = WW'(1);
        end
        else if ({21'b0, image_width_reg} > 32'(MAX_WIDTH))
        begin
            eff_width = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_width = WW'(image_width_reg);
        end
        eff_height = (image_height_reg == '0) ? 16'd1 : image_height_reg;
        half_x = ({29'b0, kernel_width_reg[3:1]} > 32'(HX_LIM))
               ? 3'(HX_LIM) : kernel_width_reg[3:1];
        half_y = ({29'b0, kernel_height_reg[3:1]} > 32'(HY_LIM))
               ? 3'(HY_LIM) : kernel_height_reg[3:1];
    end

    assign full   = front_busy || !job_empty || back_busy;
    assign accept = push && !full;

    bfr_front #(
        .CW (CW),
        .WW (WW),
        .SW (SW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (cfg_we),
        .accept     (accept),
        .req_type   (req_type),
        .pixel_in   (pixel_in),
        .eff_width  (eff_width),
        .eff_height (eff_height),
        .half_x     (half_x),
        .half_y     (half_y),
        .busy       (front_busy),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .job_push   (job_push),
        .job_word   (job_in)
    );

    bfr_fifo #(
        .WIDTH (JW),
        .DEPTH (2)
    ) u_job_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .din   (job_in),
        .full  (job_full),
        .pop   (job_pop),
        .dout  (job_out),
        .empty (job_empty)
    );

    bfr_ram #(
        .WIDTH (8),
        .DEPTH (2 ** AW)
    ) u_line_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    bfr_back #(
        .CW (CW),
        .WW (WW),
        .SW (SW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (!job_empty && !job_full ? 1'b1 : !job_empty),
        .job_word   (job_out),
        .job_pop    (job_pop),
        .eff_width  (eff_width),
        .eff_height (eff_height),
        .half_x     (half_x),
        .half_y     (half_y),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .busy       (back_busy),
        .res_push   (res_push),
        .res_word   (res_in),
        .res_full   (res_full)
    );

    bfr_fifo #(
        .WIDTH (10),
        .DEPTH (2)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_in),
        .full  (res_full),
        .pop   (pop),
        .dout  (res_out),
        .empty (empty)
    );

    assign mean_out  = res_out[9:2];
    assign row_end   = res_out[1];
    assign frame_end = res_out[0];

endmodule

// ===== design/bfr_ram.sv =====
// ----------------------------------------------------------------------------
// bfr_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/bfr_fifo.sv =====
// ----------------------------------------------------------------------------
// bfr_fifo
// Small register queue used between the front and back ends and on the output.
// ----------------------------------------------------------------------------
module bfr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = slot_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold payload words
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== design/bfr_front.sv =====
// ----------------------------------------------------------------------------
// bfr_front
// Front end: stores pixels into the line store, tracks input and output
// positions and queues one window job whenever an output becomes due.
// ----------------------------------------------------------------------------
module bfr_front #(
    parameter int CW = 10,
    parameter int WW = 11,
    parameter int SW = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   restart,
    input  logic                   accept,
    input  logic                   req_type,
    input  logic [7:0]             pixel_in,
    input  logic [WW-1:0]          eff_width,
    input  logic [15:0]            eff_height,
    input  logic [2:0]             half_x,
    input  logic [2:0]             half_y,
    output logic                   busy,
    output logic                   wr_en,
    output logic [SW+CW-1:0]       wr_addr,
    output logic [7:0]             wr_data,
    output logic                   job_push,
    output logic [16+CW+1:0]       job_word
);

    bfr_pkg::fe_state_t state_reg, state_next;

    logic [15:0]   in_row_reg, in_row_next;
    logic [CW-1:0] in_col_reg, in_col_next;
    logic [15:0]   out_row_reg, out_row_next;
    logic [CW-1:0] out_col_reg, out_col_next;
    logic          in_done_reg, in_done_next;

    logic [CW-1:0] last_col;
    logic [15:0]   last_row;
    logic [15:0]   base_row;
    logic [CW-1:0] base_col;
    logic [16:0]   need_row;
    logic [CW:0]   need_col;
    logic          ready;
    logic          row_end;
    logic          frame_end;

    assign last_col = CW'(eff_width - 1'b1);
    assign last_row = eff_height - 1'b1;
    assign busy     = (state_reg != bfr_pkg::FE_IDLE);

    // A new pixel after a finished frame starts the next frame
    assign base_row = in_done_reg ? '0 : in_row_reg;
    assign base_col = in_done_reg ? '0 : in_col_reg;

    assign wr_en   = accept && (req_type == bfr_pkg::REQ_PIXEL);
    assign wr_addr = {base_row[SW-1:0], base_col};
    assign wr_data = pixel_in;

    // Latest input position the next output needs
    always_comb
    begin
        need_row = {1'b0, out_row_reg} + {14'b0, half_y};
        if (need_row > {1'b0, last_row})
        begin
            need_row = {1'b0, last_row};
        end
        need_col = {1'b0, out_col_reg} + (CW+1)'(half_x);
        if (need_col > {1'b0, last_col})
        begin
            need_col = {1'b0, last_col};
        end
    end

    assign ready = in_done_reg
                || ({1'b0, in_row_reg} > need_row)
                || (({1'b0, in_row_reg} == need_row) && ({1'b0, in_col_reg} > need_col));
    assign row_end   = (out_col_reg == last_col);
    assign frame_end = row_end && (out_row_reg == last_row);
    assign job_push  = (state_reg == bfr_pkg::FE_CHECK) && ready;
    assign job_word  = {out_row_reg, out_col_reg, row_end, frame_end};

    // Next state and positions
    always_comb
    begin
        state_next   = state_reg;
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        in_done_next = in_done_reg;
        unique case (state_reg)
            bfr_pkg::FE_IDLE:
            begin
                if (accept)
                begin
                    state_next = bfr_pkg::FE_CHECK;
                    if (req_type == bfr_pkg::REQ_PIXEL)
                    begin
                        if (in_done_reg)
                        begin
                            out_row_next = '0;
                            out_col_next = '0;
                            in_done_next = 1'b0;
                        end
                        if (base_col == last_col)
                        begin
                            in_col_next = '0;
                            if (base_row == last_row)
                            begin
                                in_row_next  = '0;
                                in_done_next = 1'b1;
                            end
                            else
                            begin
                                in_row_next = base_row + 1'b1;
                            end
                        end
                        else
                        begin
                            in_row_next = base_row;
                            in_col_next = base_col + 1'b1;
                        end
                    end
                end
            end
            bfr_pkg::FE_CHECK:
            begin
                state_next = bfr_pkg::FE_IDLE;
                if (ready)
                begin
                    if (row_end)
                    begin
                        out_col_next = '0;
                        if (frame_end)
                        begin
                            out_row_next = '0;
                            in_done_next = 1'b0;
                        end
                        else
                        begin
                            out_row_next = out_row_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        out_col_next = out_col_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = bfr_pkg::FE_IDLE;
            end
        endcase
        if (restart)
        begin
            state_next   = bfr_pkg::FE_IDLE;
            in_row_next  = '0;
            in_col_next  = '0;
            out_row_next = '0;
            out_col_next = '0;
            in_done_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= bfr_pkg::FE_IDLE;
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            in_done_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            in_row_reg  <= in_row_next;
            in_col_reg  <= in_col_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
            in_done_reg <= in_done_next;
        end
    end

endmodule

// ===== design/bfr_back.sv =====
// ----------------------------------------------------------------------------
// bfr_back
// Back end: sums one window from the line store, one pixel a cycle with
// reflect-101 borders, then divides by the window area with rounding.
// ----------------------------------------------------------------------------
module bfr_back #(
    parameter int CW = 10,
    parameter int WW = 11,
    parameter int SW = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    input  logic [16+CW+1:0]   job_word,
    output logic               job_pop,
    input  logic [WW-1:0]      eff_width,
    input  logic [15:0]        eff_height,
    input  logic [2:0]         half_x,
    input  logic [2:0]         half_y,
    output logic [SW+CW-1:0]   rd_addr,
    input  logic [7:0]         rd_data,
    output logic               busy,
    output logic               res_push,
    output logic [9:0]         res_word,
    input  logic               res_full
);

    bfr_pkg::bk_state_t state_reg, state_next;

    logic [15:0]                 row_reg, row_next;
    logic [CW-1:0]               col_reg, col_next;
    logic                        re_reg, re_next;
    logic                        fe_reg, fe_next;
    logic [3:0]                  ix_reg, ix_next;
    logic [3:0]                  iy_reg, iy_next;
    logic                        issued_reg, issued_next;
    logic                        done_reg, done_next;
    logic [bfr_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic [bfr_pkg::SUM_W-1:0]   num_reg, num_next;
    logic [bfr_pkg::SUM_W-1:0]   quo_reg, quo_next;
    logic [bfr_pkg::AREA_W-1:0]  rem_reg, rem_next;
    logic [4:0]                  cnt_reg, cnt_next;

    logic [CW-1:0]               last_col;
    logic [15:0]                 last_row;
    logic signed [18:0]          ri;
    logic signed [CW+2:0]        ci;
    logic [3:0]                  span_x;
    logic [3:0]                  span_y;
    logic [bfr_pkg::AREA_W-1:0]  area;
    logic [bfr_pkg::AREA_W:0]    rem_sh;

    assign last_col = CW'(eff_width - 1'b1);
    assign last_row = eff_height - 1'b1;
    assign span_x   = {half_x, 1'b0};
    assign span_y   = {half_y, 1'b0};
    assign area     = {4'b0, half_x, 1'b1} * {4'b0, half_y, 1'b1};
    assign busy     = (state_reg != bfr_pkg::BK_IDLE);
    assign job_pop  = (state_reg == bfr_pkg::BK_IDLE) && job_valid;
    assign res_push = (state_reg == bfr_pkg::BK_PUT) && !res_full;
    assign res_word = {quo_reg[7:0], re_reg, fe_reg};

    // Reflect the window row about the frame edges
    always_comb
    begin
        ri = $signed({3'b0, row_reg}) + $signed({15'b0, iy_reg})
           - $signed({16'b0, half_y});
        if (ri < 0)
        begin
            ri = -ri;
        end
        if (ri > $signed({3'b0, last_row}))
        begin
            ri = $signed({2'b0, last_row, 1'b0}) - ri;
        end
        if (ri < 0)
        begin
            ri = '0;
        end
        if (ri > $signed({3'b0, last_row}))
        begin
            ri = $signed({3'b0, last_row});
        end
    end

    // Reflect the window column about the frame edges
    always_comb
    begin
        ci = $signed({3'b0, col_reg}) + $signed((CW+3)'(ix_reg))
           - $signed((CW+3)'(half_x));
        if (ci < 0)
        begin
            ci = -ci;
        end
        if (ci > $signed({3'b0, last_col}))
        begin
            ci = $signed({2'b0, last_col, 1'b0}) - ci;
        end
        if (ci < 0)
        begin
            ci = '0;
        end
        if (ci > $signed({3'b0, last_col}))
        begin
            ci = $signed({3'b0, last_col});
        end
    end

    assign rd_addr = {ri[SW-1:0], ci[CW-1:0]};
    assign rem_sh  = {rem_reg, num_reg[bfr_pkg::SUM_W-1]};

    // Sequencer: sum, divide, hand off
    always_comb
    begin
        state_next  = state_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        re_next     = re_reg;
        fe_next     = fe_reg;
        ix_next     = ix_reg;
        iy_next     = iy_reg;
        issued_next = 1'b0;
        done_next   = done_reg;
        sum_next    = sum_reg;
        num_next    = num_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        unique case (state_reg)
            bfr_pkg::BK_IDLE:
            begin
                if (job_valid)
                begin
                    {row_next, col_next, re_next, fe_next} = job_word;
                    ix_next    = '0;
                    iy_next    = '0;
                    done_next  = 1'b0;
                    sum_next   = '0;
                    state_next = bfr_pkg::BK_SUM;
                end
            end
            bfr_pkg::BK_SUM:
            begin
                // Accumulate the pixel read in the previous cycle
                if (issued_reg)
                begin
                    sum_next = sum_reg + {8'b0, rd_data};
                end
                if (!done_reg)
                begin
                    issued_next = 1'b1;
                    if (iy_reg == span_y)
                    begin
                        iy_next = '0;
                        if (ix_reg == span_x)
                        begin
                            done_next = 1'b1;
                        end
                        else
                        begin
                            ix_next = ix_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        iy_next = iy_reg + 1'b1;
                    end
                end
                else if (!issued_reg)
                begin
                    num_next   = sum_reg + {9'b0, area[7:1]};
                    rem_next   = '0;
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = bfr_pkg::BK_DIV;
                end
            end
            bfr_pkg::BK_DIV:
            begin
                // One quotient bit a cycle, restoring
                num_next = {num_reg[bfr_pkg::SUM_W-2:0], 1'b0};
                if (rem_sh >= {1'b0, area})
                begin
                    rem_next = bfr_pkg::AREA_W'(rem_sh - {1'b0, area});
                    quo_next = {quo_reg[bfr_pkg::SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[bfr_pkg::AREA_W-1:0];
                    quo_next = {quo_reg[bfr_pkg::SUM_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'(bfr_pkg::SUM_W - 1))
                begin
                    state_next = bfr_pkg::BK_PUT;
                end
            end
            bfr_pkg::BK_PUT:
            begin
                if (!res_full)
                begin
                    state_next = bfr_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = bfr_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bfr_pkg::BK_IDLE;
            issued_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Hold job and arithmetic words
    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
        col_reg <= col_next;
        re_reg  <= re_next;
        fe_reg  <= fe_next;
        ix_reg  <= ix_next;
        iy_reg  <= iy_next;
        sum_reg <= sum_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

endmodule
